// ===== rtl/ccr_pkg.sv =====
// Shared constants and types for the Chaikin curve rounds block.
package ccr_pkg;

	localparam int DEF_MAX_POINTS = 64;
	localparam int DEF_COORD_BITS = 24;
	localparam int DEF_MIN_KEEP   = 8;
	localparam int ROUNDS_BITS    = 4;

	localparam logic REG_MODE   = 1'b0;
	localparam logic REG_ROUNDS = 1'b1;

	localparam logic MODE_SUBDIV  = 1'b0;
	localparam logic MODE_REVERSE = 1'b1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ROUND,
		ST_READ,
		ST_LATCH,
		ST_HEAD,
		ST_WR_A,
		ST_WR_B,
		ST_TAIL,
		ST_EMIT_RD,
		ST_EMIT_LAT,
		ST_EMIT_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_SUB_A,
		OP_SUB_B,
		OP_REV
	} alu_op_t;

	typedef struct packed {
		logic wr_en;
		logic wr_sel;
		logic rd_sel;
	} mem_ctl_t;

endpackage

// ===== rtl/ccr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ccr_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ccr_alu.sv =====
// Shared 4-tap weighted sum with floor divide by four and saturation, x and y lanes.
module ccr_alu import ccr_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  alu_op_t                 op,
	input  logic [2*COORD_BITS-1:0] win [4],
	output logic [2*COORD_BITS-1:0] res,
	output logic                    sat
);

	localparam int C  = COORD_BITS;
	localparam int SW = COORD_BITS + 4;
	localparam logic [SW-1:0] HI = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
	localparam logic [SW-1:0] LO = {{(SW-C+1){1'b1}}, {(C-1){1'b0}}};

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [SW-1:0] a [4];
		logic signed [SW-1:0] t0, t1, t2, t3, sum, quo;
		logic [C-1:0]         lres;
		logic                 lsat;

		always_comb begin
			for (int i = 0; i < 4; i++) begin
				a[i] = {{(SW-C){win[i][l*C+C-1]}}, win[i][l*C +: C]};
			end
			t0 = '0;
			t1 = '0;
			t2 = a[2];
			t3 = a[3];
			unique case (op)
				OP_SUB_A: begin
					t2 = (a[2] <<< 1) + a[2];
				end
				OP_SUB_B: begin
					t3 = (a[3] <<< 1) + a[3];
				end
				OP_REV: begin
					t0 = -a[0];
					t1 = (a[1] <<< 1) + a[1];
					t2 = (a[2] <<< 1) + a[2];
					t3 = -a[3];
				end
				default: begin
					t2 = a[2];
				end
			endcase
			sum = t0 + t1 + t2 + t3;
			// arithmetic shift gives the floor
			quo = sum >>> 2;
			lsat = 1'b0;
			if (quo > $signed(HI)) begin
				lres = HI[C-1:0];
				lsat = 1'b1;
			end else if (quo < $signed(LO)) begin
				lres = LO[C-1:0];
				lsat = 1'b1;
			end else begin
				lres = quo[C-1:0];
			end
		end
	end

	assign res = {g_lane[1].lres, g_lane[0].lres};
	assign sat = g_lane[1].lsat | g_lane[0].lsat;

endmodule

// ===== rtl/ccr_ctrl.sv =====
// Sequencer: load, per-round buffer walk through the shared ALU, and result emission.
module ccr_ctrl import ccr_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int MIN_KEEP   = DEF_MIN_KEEP
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mode,
	input  logic [ROUNDS_BITS-1:0]        rounds,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  x_coord,
	input  logic signed [COORD_BITS-1:0]  y_coord,
	input  logic                          is_final,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS-1:0]  out_x,
	output logic signed [COORD_BITS-1:0]  out_y,
	output logic                          end_of_run,
	output logic                          overflow_flag,
	output mem_ctl_t                      mem_ctl,
	output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
	output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
	output logic [2*COORD_BITS-1:0]       wr_data,
	input  logic [2*COORD_BITS-1:0]       rd_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int PW = 2 * COORD_BITS;

	state_t state_q, state_nxt;

	logic [CW-1:0]          n_q, k_q;
	logic [AW-1:0]          j_q;
	logic [ROUNDS_BITS-1:0] r_q;
	logic                   sticky_q, src_q;
	logic [PW-1:0]          win_q [4];

	logic [PW-1:0] alu_res;
	logic          alu_sat;
	alu_op_t       alu_op;

	logic full, too_big, at_min, last_rd, rounds_done, step_j, in_acc, out_acc;

	assign full        = (n_q == CW'(MAX_POINTS));
	assign too_big     = ({n_q, 1'b0} > (CW+1)'(MAX_POINTS));
	assign at_min      = (n_q <= CW'(MIN_KEEP));
	assign last_rd     = (CW'(j_q) == n_q - 1'b1);
	assign rounds_done = (r_q >= rounds);
	assign in_acc      = in_valid && in_ready;
	assign out_acc     = out_valid && out_ready;

	ccr_alu #(.COORD_BITS(COORD_BITS)) u_alu (
		.op  (alu_op),
		.win (win_q),
		.res (alu_res),
		.sat (alu_sat)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid && is_final) state_nxt = ST_ROUND;
			end
			ST_ROUND: begin
				if (rounds_done) begin
					state_nxt = ST_EMIT_RD;
				end else if (mode == MODE_SUBDIV) begin
					state_nxt = too_big ? ST_ROUND : ST_READ;
				end else begin
					state_nxt = at_min ? ST_EMIT_RD : ST_READ;
				end
			end
			ST_READ: state_nxt = ST_LATCH;
			ST_LATCH: begin
				if (j_q == '0) begin
					state_nxt = ST_HEAD;
				end else if (mode == MODE_SUBDIV) begin
					state_nxt = ST_WR_A;
				end else if (j_q[0] && j_q >= AW'(3)) begin
					state_nxt = ST_WR_A;
				end else begin
					state_nxt = last_rd ? ST_TAIL : ST_READ;
				end
			end
			ST_HEAD: state_nxt = last_rd ? ST_TAIL : ST_READ;
			ST_WR_A: begin
				if (mode == MODE_SUBDIV) state_nxt = ST_WR_B;
				else state_nxt = last_rd ? ST_TAIL : ST_READ;
			end
			ST_WR_B:     state_nxt = last_rd ? ST_TAIL : ST_READ;
			ST_TAIL:     state_nxt = ST_ROUND;
			ST_EMIT_RD:  state_nxt = ST_EMIT_LAT;
			ST_EMIT_LAT: state_nxt = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (out_ready) state_nxt = last_rd ? ST_LOAD : ST_EMIT_RD;
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		mem_ctl.wr_en  = 1'b0;
		mem_ctl.wr_sel = ~src_q;
		mem_ctl.rd_sel = src_q;
		wr_addr        = k_q[AW-1:0];
		wr_data        = alu_res;
		rd_addr        = j_q;
		alu_op         = OP_SUB_A;
		step_j         = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready       = 1'b1;
				mem_ctl.wr_en  = in_valid && !full;
				mem_ctl.wr_sel = src_q;
				wr_addr        = n_q[AW-1:0];
				wr_data        = {x_coord, y_coord};
			end
			ST_HEAD, ST_TAIL: begin
				mem_ctl.wr_en = 1'b1;
				wr_data       = win_q[3];
			end
			ST_WR_A: begin
				mem_ctl.wr_en = 1'b1;
				alu_op        = (mode == MODE_SUBDIV) ? OP_SUB_A : OP_REV;
			end
			ST_WR_B: begin
				mem_ctl.wr_en = 1'b1;
				alu_op        = OP_SUB_B;
			end
			ST_EMIT_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		if (state_nxt == ST_READ && state_q != ST_ROUND && state_q != ST_READ) step_j = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			n_q      <= '0;
			k_q      <= '0;
			j_q      <= '0;
			r_q      <= '0;
			sticky_q <= 1'b0;
			src_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) sticky_q <= 1'b1;
						else n_q <= n_q + 1'b1;
						r_q <= '0;
					end
				end
				ST_ROUND: begin
					j_q <= '0;
					k_q <= '0;
					// skip a subdivide round that would not fit
					if (!rounds_done && mode == MODE_SUBDIV && too_big) begin
						sticky_q <= 1'b1;
						r_q      <= r_q + 1'b1;
					end
				end
				ST_HEAD: begin
					k_q <= k_q + 1'b1;
				end
				ST_WR_A, ST_WR_B: begin
					k_q <= k_q + 1'b1;
					if (alu_sat) sticky_q <= 1'b1;
				end
				ST_TAIL: begin
					// new polyline lives in the other buffer now
					n_q   <= k_q + 1'b1;
					src_q <= ~src_q;
					r_q   <= r_q + 1'b1;
				end
				ST_EMIT_OUT: begin
					if (out_acc) begin
						if (last_rd) begin
							n_q      <= '0;
							sticky_q <= 1'b0;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				default: begin
					sticky_q <= sticky_q;
				end
			endcase
			if (step_j) j_q <= j_q + 1'b1;
		end
	end

	// sliding window over the source buffer
	always_ff @(posedge clk) begin
		if (state_q == ST_LATCH) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= rd_data;
		end
		if (state_q == ST_EMIT_LAT) begin
			out_x         <= rd_data[PW-1:COORD_BITS];
			out_y         <= rd_data[COORD_BITS-1:0];
			end_of_run    <= last_rd;
			overflow_flag <= sticky_q;
		end
	end

endmodule

// ===== rtl/chaikin_curve_rounds.sv =====
// Top level: register port, ping-pong point buffers and the round sequencer.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-----------------------------------------
//   input     | in_valid / in_ready  | x_coord, y_coord, is_final
//   output    | out_valid / out_ready| out_x, out_y, end_of_run, overflow_flag
//   config    | psel, penable, pwrite| paddr, pwdata, prdata (pready tied high)
//
// Points load one per cycle; in_ready drops from the final point until the last
// result is taken. Each round walks the source buffer through the shared ALU:
// each point is read, then latched into the window, and each point written has
// its own state (head, A, B or tail). Each result is read, latched and output,
// held while out_ready is low. Buffers hold no reset state; the point count and
// the sticky overflow state clear at reset and after each run.
module chaikin_curve_rounds import ccr_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int MIN_KEEP   = DEF_MIN_KEEP
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         is_final,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic                         end_of_run,
	output logic                         overflow_flag
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int PW = 2 * COORD_BITS;

	logic                   mode_q;
	logic [ROUNDS_BITS-1:0] rounds_q;

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [PW-1:0] wr_data, rd_a, rd_b, rd_data;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			rounds_q <= ROUNDS_BITS'(1);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_MODE:   mode_q   <= pwdata[0];
				REG_ROUNDS: rounds_q <= pwdata[ROUNDS_BITS-1:0];
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE:   prdata = {31'd0, mode_q};
			REG_ROUNDS: prdata = {{(32-ROUNDS_BITS){1'b0}}, rounds_q};
			default:    prdata = '0;
		endcase
	end

	ccr_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_buf_a (
		.clk   (clk),
		.we    (mem_ctl.wr_en && !mem_ctl.wr_sel),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_a)
	);

	ccr_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_buf_b (
		.clk   (clk),
		.we    (mem_ctl.wr_en && mem_ctl.wr_sel),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_b)
	);

	assign rd_data = mem_ctl.rd_sel ? rd_b : rd_a;

	ccr_ctrl #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.MIN_KEEP   (MIN_KEEP)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode_q),
		.rounds        (rounds_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.is_final      (is_final),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_x         (out_x),
		.out_y         (out_y),
		.end_of_run    (end_of_run),
		.overflow_flag (overflow_flag),
		.mem_ctl       (mem_ctl),
		.rd_addr       (rd_addr),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_data       (rd_data)
	);

endmodule
